@@ sv/plwu_pkg.sv @@
// shared types, codes and constants for the particle landmark weight update
// no dependencies
package plwu_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 68;
    localparam int ACC_W        = 70;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LANDMARKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_LOG_NORM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY  = 3'd5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_OBS   = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [15:0]        heading;
        logic [15:0]        landmark_tag;
        logic               final_obs;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic [15:0]        matched_tag;
        logic               matched;
        logic [30:0]        exponent_term;
        logic signed [31:0] neg_log_weight;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        tag;
    } t_mark;

    typedef enum logic [4:0] {
        ST_IDLE, ST_B_R2, ST_B_R2W, ST_B_RD, ST_B_DX, ST_B_DY, ST_B_CMP,
        ST_CORD, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
        ST_S_RD, ST_S_DX, ST_S_DY, ST_S_CMP,
        ST_E_CHK, ST_E_X2, ST_E_X3, ST_E_X4, ST_E_Y2, ST_E_Y3, ST_E_Y4,
        ST_WT
    } t_state;

    function automatic logic [31:0] atan_q32(input logic [4:0] i);
        case (i)
            5'd0:  atan_q32 = 32'd536870912;
            5'd1:  atan_q32 = 32'd316933406;
            5'd2:  atan_q32 = 32'd167458907;
            5'd3:  atan_q32 = 32'd85004756;
            5'd4:  atan_q32 = 32'd42667331;
            5'd5:  atan_q32 = 32'd21354465;
            5'd6:  atan_q32 = 32'd10679838;
            5'd7:  atan_q32 = 32'd5340245;
            5'd8:  atan_q32 = 32'd2670163;
            5'd9:  atan_q32 = 32'd1335087;
            5'd10: atan_q32 = 32'd667544;
            5'd11: atan_q32 = 32'd333772;
            5'd12: atan_q32 = 32'd166886;
            5'd13: atan_q32 = 32'd83443;
            5'd14: atan_q32 = 32'd41722;
            5'd15: atan_q32 = 32'd20861;
            5'd16: atan_q32 = 32'd10430;
            5'd17: atan_q32 = 32'd5215;
            5'd18: atan_q32 = 32'd2608;
            5'd19: atan_q32 = 32'd1304;
            5'd20: atan_q32 = 32'd652;
            5'd21: atan_q32 = 32'd326;
            5'd22: atan_q32 = 32'd163;
            5'd23: atan_q32 = 32'd81;
            5'd24: atan_q32 = 32'd41;
            5'd25: atan_q32 = 32'd20;
            5'd26: atan_q32 = 32'd10;
            5'd27: atan_q32 = 32'd5;
            5'd28: atan_q32 = 32'd3;
            5'd29: atan_q32 = 32'd1;
            default: atan_q32 = 32'd0;
        endcase
    endfunction

endpackage

@@ sv/plwu_mult.sv @@
// shared signed multiplier with registered product
// depends on plwu_pkg
module plwu_mult (
    input  logic                                i_clk,
    input  logic signed [plwu_pkg::MUL_W-1:0]   i_a,
    input  logic signed [plwu_pkg::MUL_W-1:0]   i_b,
    output logic signed [plwu_pkg::PROD_W-1:0]  o_p
);

    logic signed [plwu_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ sv/plwu_cordic.sv @@
// iterative cordic, one rotation step per cycle, gives cos and sin in q4.30
// depends on plwu_pkg
module plwu_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [15:0]                            i_heading,
    output logic                                   o_done,
    output logic signed [plwu_pkg::CORDIC_W-1:0]   o_cos,
    output logic signed [plwu_pkg::CORDIC_W-1:0]   o_sin
);

    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [31:0] w_ang, w_sum, w_fold;
    logic        w_flip;
    logic signed [plwu_pkg::CORDIC_W-1:0] w_xs, w_ys, w_at;

    logic signed [plwu_pkg::CORDIC_W-1:0] r_x, r_y, r_z;
    logic        r_flip, r_run, r_done;
    logic [4:0]  r_i;

    // fold into a quarter turn either side of zero
    assign w_ang  = (32'(i_heading) & AMASK) << (32 - ANGLE_BITS);
    assign w_sum  = w_ang + 32'h4000_0000;
    assign w_flip = w_sum[31];
    assign w_fold = w_flip ? w_ang + 32'h8000_0000 : w_ang;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed({2'b00, plwu_pkg::atan_q32(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_i    <= 5'd0;
                r_x    <= plwu_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= $signed({{2{w_fold[31]}}, w_fold});
                r_flip <= w_flip;
            end else if (r_run) begin
                if (!r_z[plwu_pkg::CORDIC_W-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(plwu_pkg::CORDIC_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

@@ sv/plwu_lmtab.sv @@
// landmark table memory, one write and one registered read port
// depends on plwu_pkg
module plwu_lmtab #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  plwu_pkg::t_mark       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output plwu_pkg::t_mark       o_rdata
);

    plwu_pkg::t_mark r_mem [DEPTH];
    plwu_pkg::t_mark r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/particle_landmark_weight_update.sv @@
// particle weight update by nearest landmark matching, top level
// depends on plwu_pkg, plwu_mult, plwu_cordic, plwu_lmtab
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_item (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// after a begin item o_in_ready stays low while each enabled landmark is tested against the
// sensor range; after an observation while the 30-step cordic loop runs, in-range landmarks
// are scanned on the single shared multiplier and a match gives the exponent term; a result
// blocked by a full output register holds the last step
// synchronous active-low reset; the landmark table is not cleared
// a finished result waits in the output register while the next item is taken
module particle_landmark_weight_update #(
    parameter int MAX_LANDMARKS = 64,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  plwu_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output plwu_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [plwu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CW = $clog2(MAX_LANDMARKS + 1) + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_LANDMARKS);
    localparam int MW = plwu_pkg::MUL_W;
    localparam int PW = plwu_pkg::PROD_W;
    localparam int AC = plwu_pkg::ACC_W;

    function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        absdiff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AC-1:0] v);
        if (v > 70'sd2147483647)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -70'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    plwu_pkg::t_state r_state, n_state;

    // configuration
    logic [6:0]          r_num;
    logic [30:0]         r_range;
    logic [23:0]         r_isx, r_isy;
    logic signed [31:0]  r_nln;
    logic [30:0]         r_miss;

    // particle and datapath state
    logic signed [31:0]  r_pose_x, r_pose_y, r_weight;
    logic [15:0]         r_pose_hd;
    logic [MAX_LANDMARKS-1:0] r_mask;
    logic [CW-1:0]       r_j, r_n;
    logic signed [AC-1:0] r_acc;
    logic [61:0]         r_r2;
    logic [63:0]         r_best;
    logic                r_found;
    logic signed [31:0]  r_bx, r_by, r_wx, r_wy, r_ox, r_oy;
    logic [15:0]         r_btag;
    logic                r_fin;
    logic [31:0]         r_lo;
    logic [56:0]         r_tx;
    logic [30:0]         r_expo;
    logic                r_out_valid;
    plwu_pkg::t_out_item r_out;

    logic                in_acc, cfg_acc, w_start, w_cdone, w_load;
    logic signed [MW-1:0] w_ma, w_mb, w_cos, w_sin;
    logic signed [PW-1:0] w_prod;
    logic signed [AC-1:0] w_prodx, w_rot, w_sh, w_pos;
    logic [64:0]         w_dsum;
    logic [63:0]         w_dsat;
    logic [57:0]         w_esum;
    logic signed [33:0]  w_wsum;
    logic                w_we;
    plwu_pkg::t_mark     w_wdata, w_rd;
    logic [CW-1:0]       w_numc;

    assign o_in_ready  = (r_state == plwu_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid;

    assign w_we = in_acc && (i_in_item.opcode == plwu_pkg::OP_LOAD)
               && (11'(i_in_item.index) < 11'(MAX_LANDMARKS));
    assign w_wdata = '{x: i_in_item.coord_x, y: i_in_item.coord_y,
                       tag: i_in_item.landmark_tag};
    assign w_start = in_acc && (i_in_item.opcode == plwu_pkg::OP_OBS);

    plwu_lmtab #(.DEPTH(MAX_LANDMARKS), .AW(AW)) u_tab (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in_item.index)),
        .i_wdata (w_wdata),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (w_rd)
    );

    plwu_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_heading (r_pose_hd),
        .o_done    (w_cdone),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    plwu_mult u_mult (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            plwu_pkg::ST_B_R2: begin
                w_ma = $signed({3'b000, r_range});
                w_mb = $signed({3'b000, r_range});
            end
            plwu_pkg::ST_B_DX: begin
                w_ma = $signed({2'b00, absdiff(w_rd.x, r_pose_x)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_B_DY: begin
                w_ma = $signed({2'b00, absdiff(w_rd.y, r_pose_y)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_R1: begin
                w_ma = w_cos;
                w_mb = MW'(r_ox);
            end
            plwu_pkg::ST_R2: begin
                w_ma = w_sin;
                w_mb = MW'(r_oy);
            end
            plwu_pkg::ST_R3: begin
                w_ma = w_sin;
                w_mb = MW'(r_ox);
            end
            plwu_pkg::ST_R4: begin
                w_ma = w_cos;
                w_mb = MW'(r_oy);
            end
            plwu_pkg::ST_S_DX: begin
                w_ma = $signed({2'b00, absdiff(w_rd.x, r_wx)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_S_DY: begin
                w_ma = $signed({2'b00, absdiff(w_rd.y, r_wy)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_E_CHK: begin
                w_ma = $signed({2'b00, absdiff(r_wx, r_bx)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_E_X4: begin
                w_ma = $signed({2'b00, absdiff(r_wy, r_by)});
                w_mb = w_ma;
            end
            plwu_pkg::ST_E_X2: begin
                w_ma = $signed({2'b00, w_prod[63:32]});
                w_mb = $signed({10'd0, r_isx});
            end
            plwu_pkg::ST_E_X3: begin
                w_ma = $signed({2'b00, r_lo});
                w_mb = $signed({10'd0, r_isx});
            end
            plwu_pkg::ST_E_Y2: begin
                w_ma = $signed({2'b00, w_prod[63:32]});
                w_mb = $signed({10'd0, r_isy});
            end
            plwu_pkg::ST_E_Y3: begin
                w_ma = $signed({2'b00, r_lo});
                w_mb = $signed({10'd0, r_isy});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prodx = AC'(w_prod);
    assign w_rot   = ((r_state == plwu_pkg::ST_R3) ? r_acc - w_prodx : r_acc + w_prodx)
                   + 70'sd536870912;
    assign w_sh    = w_rot >>> 30;
    assign w_pos   = w_sh + AC'((r_state == plwu_pkg::ST_R3) ? r_pose_x : r_pose_y);

    assign w_dsum  = {1'b0, r_acc[63:0]} + {1'b0, w_prod[63:0]};
    assign w_dsat  = w_dsum[64] ? '1 : w_dsum[63:0];
    assign w_esum  = {1'b0, r_tx} + {1'b0, r_acc[56:0]} + 58'(w_prod[55:32]);
    assign w_wsum  = 34'(r_weight) + 34'(r_nln) + $signed({3'b000, r_expo});
    assign w_load  = (r_state == plwu_pkg::ST_WT) && (!r_out_valid || i_out_ready);
    assign w_numc  = (16'(r_num) > 16'(MAX_LANDMARKS)) ? MAXC : CW'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plwu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            plwu_pkg::ST_IDLE: begin
                if (in_acc && i_in_item.opcode == plwu_pkg::OP_BEGIN)
                    n_state = plwu_pkg::ST_B_R2;
                else if (in_acc && i_in_item.opcode == plwu_pkg::OP_OBS)
                    n_state = plwu_pkg::ST_CORD;
            end
            plwu_pkg::ST_B_R2:  n_state = plwu_pkg::ST_B_R2W;
            plwu_pkg::ST_B_R2W: n_state = plwu_pkg::ST_B_RD;
            plwu_pkg::ST_B_RD: begin
                n_state = (r_j == r_n) ? plwu_pkg::ST_IDLE : plwu_pkg::ST_B_DX;
            end
            plwu_pkg::ST_B_DX:  n_state = plwu_pkg::ST_B_DY;
            plwu_pkg::ST_B_DY:  n_state = plwu_pkg::ST_B_CMP;
            plwu_pkg::ST_B_CMP: n_state = plwu_pkg::ST_B_RD;
            plwu_pkg::ST_CORD: begin
                if (w_cdone)
                    n_state = plwu_pkg::ST_R1;
            end
            plwu_pkg::ST_R1: n_state = plwu_pkg::ST_R2;
            plwu_pkg::ST_R2: n_state = plwu_pkg::ST_R3;
            plwu_pkg::ST_R3: n_state = plwu_pkg::ST_R4;
            plwu_pkg::ST_R4: n_state = plwu_pkg::ST_R5;
            plwu_pkg::ST_R5: n_state = plwu_pkg::ST_S_RD;
            plwu_pkg::ST_S_RD: begin
                if (r_j == MAXC)
                    n_state = plwu_pkg::ST_E_CHK;
                else if (r_mask[r_j[AW-1:0]])
                    n_state = plwu_pkg::ST_S_DX;
            end
            plwu_pkg::ST_S_DX:  n_state = plwu_pkg::ST_S_DY;
            plwu_pkg::ST_S_DY:  n_state = plwu_pkg::ST_S_CMP;
            plwu_pkg::ST_S_CMP: n_state = plwu_pkg::ST_S_RD;
            plwu_pkg::ST_E_CHK: begin
                n_state = r_found ? plwu_pkg::ST_E_X2 : plwu_pkg::ST_WT;
            end
            plwu_pkg::ST_E_X2: n_state = plwu_pkg::ST_E_X3;
            plwu_pkg::ST_E_X3: n_state = plwu_pkg::ST_E_X4;
            plwu_pkg::ST_E_X4: n_state = plwu_pkg::ST_E_Y2;
            plwu_pkg::ST_E_Y2: n_state = plwu_pkg::ST_E_Y3;
            plwu_pkg::ST_E_Y3: n_state = plwu_pkg::ST_E_Y4;
            plwu_pkg::ST_E_Y4: n_state = plwu_pkg::ST_WT;
            plwu_pkg::ST_WT: begin
                if (w_load)
                    n_state = plwu_pkg::ST_IDLE;
            end
            default: n_state = plwu_pkg::ST_IDLE;
        endcase
    end

    // configuration and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= 7'd0;
            r_range     <= 31'd3276800;
            r_isx       <= 24'd65536;
            r_isy       <= 24'd65536;
            r_nln       <= '0;
            r_miss      <= 31'h7FFF_FFFF;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_pose_hd   <= '0;
            r_weight    <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    plwu_pkg::CFG_NUM_LANDMARKS: r_num   <= i_cfg_data[6:0];
                    plwu_pkg::CFG_SENSOR_RANGE:  r_range <= i_cfg_data[30:0];
                    plwu_pkg::CFG_INV_SX:        r_isx   <= i_cfg_data[23:0];
                    plwu_pkg::CFG_INV_SY:        r_isy   <= i_cfg_data[23:0];
                    plwu_pkg::CFG_NEG_LOG_NORM:  r_nln   <= $signed(i_cfg_data);
                    plwu_pkg::CFG_MISS_PENALTY:  r_miss  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_acc && i_in_item.opcode == plwu_pkg::OP_BEGIN) begin
                r_pose_x  <= i_in_item.coord_x;
                r_pose_y  <= i_in_item.coord_y;
                r_pose_hd <= i_in_item.heading;
                r_weight  <= '0;
                r_mask    <= '0;
            end
            if (r_state == plwu_pkg::ST_B_CMP)
                r_mask[r_j[AW-1:0]] <= ({2'b00, w_dsat} < {4'd0, r_r2});
            if (w_load) begin
                r_weight    <= sat32(AC'(w_wsum));
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            plwu_pkg::ST_IDLE: begin
                r_ox  <= i_in_item.coord_x;
                r_oy  <= i_in_item.coord_y;
                r_fin <= i_in_item.final_obs;
                r_j   <= '0;
                r_n   <= w_numc;
            end
            plwu_pkg::ST_B_R2W: r_r2  <= w_prod[61:0];
            plwu_pkg::ST_B_DY:  r_acc <= w_prodx;
            plwu_pkg::ST_B_CMP: r_j   <= r_j + 1'b1;
            plwu_pkg::ST_R2:    r_acc <= w_prodx;
            plwu_pkg::ST_R3:    r_wx  <= sat32(w_pos);
            plwu_pkg::ST_R4:    r_acc <= w_prodx;
            plwu_pkg::ST_R5: begin
                r_wy    <= sat32(w_pos);
                r_j     <= '0;
                r_found <= 1'b0;
            end
            plwu_pkg::ST_S_RD: begin
                if (r_j != MAXC && !r_mask[r_j[AW-1:0]])
                    r_j <= r_j + 1'b1;
            end
            plwu_pkg::ST_S_DY: r_acc <= w_prodx;
            plwu_pkg::ST_S_CMP: begin
                if (!r_found || w_dsat < r_best) begin
                    r_found <= 1'b1;
                    r_best  <= w_dsat;
                    r_bx    <= w_rd.x;
                    r_by    <= w_rd.y;
                    r_btag  <= w_rd.tag;
                end
                r_j <= r_j + 1'b1;
            end
            plwu_pkg::ST_E_CHK: begin
                if (!r_found)
                    r_expo <= r_miss;
            end
            plwu_pkg::ST_E_X2: r_lo  <= w_prod[31:0];
            plwu_pkg::ST_E_X3: r_acc <= w_prodx;
            plwu_pkg::ST_E_X4: r_tx  <= r_acc[56:0] + 57'(w_prod[55:32]);
            plwu_pkg::ST_E_Y2: r_lo  <= w_prod[31:0];
            plwu_pkg::ST_E_Y3: r_acc <= w_prodx;
            plwu_pkg::ST_E_Y4: begin
                r_tx   <= '0;
                r_expo <= (w_esum > 58'h7FFF_FFFF) ? 31'h7FFF_FFFF : w_esum[30:0];
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.world_x        <= r_wx;
            r_out.world_y        <= r_wy;
            r_out.matched_tag    <= r_found ? r_btag : 16'd0;
            r_out.matched        <= r_found;
            r_out.exponent_term  <= r_expo;
            r_out.neg_log_weight <= sat32(AC'(w_wsum));
            r_out.last           <= r_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ sim/plwu_result_checker.sv @@
`timescale 1ns / 1ps
// watches the item, result and register channels of particle_landmark_weight_update,
// predicts every result and compares it field by field; depends on plwu_pkg
module plwu_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  plwu_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  plwu_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [plwu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_mismatches,
    output int                  o_pending
);

    localparam int TABLE_DEPTH = 64;
    localparam int ROT_STEPS   = 30;
    localparam longint ROT_GAIN = 652032874;
    localparam longint ATAN_Q32 [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic [6:0]  reg_num_marks;
    logic [30:0] reg_range;
    logic [23:0] reg_inv_x;
    logic [23:0] reg_inv_y;
    int          reg_norm;
    logic [30:0] reg_miss;

    int          tab_x [TABLE_DEPTH];
    int          tab_y [TABLE_DEPTH];
    logic [15:0] tab_tag [TABLE_DEPTH];
    bit          visible [TABLE_DEPTH];
    int          pose_x;
    int          pose_y;
    logic [15:0] pose_hd;
    int          weight;

    plwu_pkg::t_out_item expected_obs_q [$];
    int          err_cnt;

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint unsigned gap(input int a, input int b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic longint unsigned sq_dist(input int ax, input int ay,
                                                input int bx, input int by);
        longint unsigned dx, dy, s;
        dx = gap(ax, bx);
        dy = gap(ay, by);
        s = dx * dx + dy * dy;
        if (s < dx * dx) s = '1;
        return s;
    endfunction

    function automatic longint unsigned gauss_term(input longint unsigned d,
                                                   input logic [23:0] inv);
        longint unsigned a;
        a = d * d;
        return (a >> 32) * inv + (((a & 64'hFFFF_FFFF) * inv) >> 32);
    endfunction

    function automatic void heading_sincos(input logic [15:0] hd,
                                           output longint c, output longint s);
        logic [31:0] ang;
        bit          flip;
        longint      x, y, z, xs, ys;
        ang = {hd, 16'h0};
        flip = 0;
        x = ROT_GAIN;
        y = 0;
        if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            flip = 1;
            ang = ang + 32'h8000_0000;
        end
        z = longint'(int'(ang));
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_Q32[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_Q32[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic plwu_pkg::t_out_item predict_obs(input plwu_pkg::t_in_item it);
        plwu_pkg::t_out_item r;
        longint c, s, ox, oy;
        longint unsigned best, d, expo;
        int wx, wy, bj;
        bit found;
        heading_sincos(pose_hd, c, s);
        ox = longint'(it.coord_x);
        oy = longint'(it.coord_y);
        wx = clamp32(longint'(pose_x) + ((c * ox - s * oy + (64'sd1 <<< 29)) >>> 30));
        wy = clamp32(longint'(pose_y) + ((s * ox + c * oy + (64'sd1 <<< 29)) >>> 30));
        found = 0;
        best = 0;
        bj = 0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (visible[j]) begin
                d = sq_dist(tab_x[j], tab_y[j], wx, wy);
                if (!found || d < best) begin
                    found = 1; best = d; bj = j;
                end
            end
        end
        if (found) begin
            expo = gauss_term(gap(wx, tab_x[bj]), reg_inv_x)
                 + gauss_term(gap(wy, tab_y[bj]), reg_inv_y);
            if (expo > 64'h7FFF_FFFF) expo = 64'h7FFF_FFFF;
        end else begin
            expo = 64'(reg_miss);
        end
        weight = clamp32(longint'(weight) + longint'(reg_norm) + longint'(expo));
        r.world_x = wx;
        r.world_y = wy;
        r.matched_tag = found ? tab_tag[bj] : 16'h0;
        r.matched = found;
        r.exponent_term = expo[30:0];
        r.neg_log_weight = weight;
        r.last = it.final_obs;
        return r;
    endfunction

    function automatic void take_pose(input plwu_pkg::t_in_item it);
        int n;
        longint unsigned r2;
        n = (reg_num_marks < TABLE_DEPTH) ? reg_num_marks : TABLE_DEPTH;
        r2 = longint'(reg_range) * longint'(reg_range);
        pose_x = it.coord_x;
        pose_y = it.coord_y;
        pose_hd = it.heading;
        weight = 0;
        for (int j = 0; j < TABLE_DEPTH; j++)
            visible[j] = (j < n) && (sq_dist(tab_x[j], tab_y[j], pose_x, pose_y) < r2);
    endfunction

    task automatic report(input string what, input longint want, input longint got);
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        plwu_pkg::t_out_item e;
        if (!i_rst_n) begin
            reg_num_marks = 0;
            reg_range = 31'd3276800;
            reg_inv_x = 24'd65536;
            reg_inv_y = 24'd65536;
            reg_norm = 0;
            reg_miss = 31'h7FFF_FFFF;
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                tab_x[j] = 0; tab_y[j] = 0; tab_tag[j] = 0; visible[j] = 0;
            end
            pose_x = 0;
            pose_y = 0;
            pose_hd = 0;
            weight = 0;
            expected_obs_q.delete();
            err_cnt = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_obs_q.size() == 0) begin
                    $display("%0t mismatch result with none expected: expected none actual %h",
                             $time, i_out_item);
                    err_cnt++;
                end else begin
                    e = expected_obs_q.pop_front();
                    if (e.world_x !== i_out_item.world_x)
                        report("world_x", e.world_x, i_out_item.world_x);
                    if (e.world_y !== i_out_item.world_y)
                        report("world_y", e.world_y, i_out_item.world_y);
                    if (e.matched_tag !== i_out_item.matched_tag)
                        report("matched_tag", e.matched_tag, i_out_item.matched_tag);
                    if (e.matched !== i_out_item.matched)
                        report("matched", e.matched, i_out_item.matched);
                    if (e.exponent_term !== i_out_item.exponent_term)
                        report("exponent_term", e.exponent_term, i_out_item.exponent_term);
                    if (e.neg_log_weight !== i_out_item.neg_log_weight)
                        report("neg_log_weight", e.neg_log_weight, i_out_item.neg_log_weight);
                    if (e.last !== i_out_item.last)
                        report("last", e.last, i_out_item.last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    plwu_pkg::CFG_NUM_LANDMARKS: reg_num_marks = i_cfg_data[6:0];
                    plwu_pkg::CFG_SENSOR_RANGE:  reg_range = i_cfg_data[30:0];
                    plwu_pkg::CFG_INV_SX:        reg_inv_x = i_cfg_data[23:0];
                    plwu_pkg::CFG_INV_SY:        reg_inv_y = i_cfg_data[23:0];
                    plwu_pkg::CFG_NEG_LOG_NORM:  reg_norm = i_cfg_data;
                    plwu_pkg::CFG_MISS_PENALTY:  reg_miss = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.opcode)
                    plwu_pkg::OP_LOAD: begin
                        tab_x[i_in_item.index] = i_in_item.coord_x;
                        tab_y[i_in_item.index] = i_in_item.coord_y;
                        tab_tag[i_in_item.index] = i_in_item.landmark_tag;
                    end
                    plwu_pkg::OP_BEGIN: take_pose(i_in_item);
                    plwu_pkg::OP_OBS:
                        expected_obs_q.insert(expected_obs_q.size(), predict_obs(i_in_item));
                    default: ;
                endcase
            end
        end
        o_mismatches <= err_cnt;
        o_pending <= expected_obs_q.size();
    end

endmodule

@@ sim/particle_landmark_weight_update_tb.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for particle_landmark_weight_update: landmark loads, particle
// sequences, register phases and random stalls; depends on plwu_pkg and plwu_result_checker
module particle_landmark_weight_update_tb;

    localparam int METER = 65536;
    localparam int SETTLE_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    plwu_pkg::t_in_item  i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    plwu_pkg::t_out_item o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [plwu_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    int mismatches;
    int pending;
    int items_sent;
    bit tx_gaps;
    int rx_gap_odds;
    bit rx_long_hold;

    particle_landmark_weight_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    plwu_result_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int n;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                i_out_ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                rx_long_hold = 0;
            end else if (rx_gap_odds > 0 && $urandom_range(0, 99) < rx_gap_odds) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int near_coord(input int span_m);
        return int'($urandom_range(0, 2 * span_m * METER)) - span_m * METER;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic plwu_pkg::t_in_item make_item(input logic [1:0] op, input int x,
                                                     input int y);
        plwu_pkg::t_in_item it;
        it.opcode = op;
        it.index = 6'($urandom_range(0, 63));
        it.coord_x = x;
        it.coord_y = y;
        it.heading = 16'($urandom_range(0, 65535));
        it.landmark_tag = 16'($urandom_range(0, 65535));
        it.final_obs = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(input plwu_pkg::t_in_item it);
        int n;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] num, input logic [31:0] range,
                              input logic [31:0] inv_x, input logic [31:0] inv_y,
                              input logic [31:0] norm, input logic [31:0] miss);
        logic [31:0] vals [6];
        logic [plwu_pkg::CFG_IDX_W-1:0] idx [6];
        vals = '{num, range, inv_x, inv_y, norm, miss};
        idx = '{plwu_pkg::CFG_NUM_LANDMARKS, plwu_pkg::CFG_SENSOR_RANGE,
                plwu_pkg::CFG_INV_SX, plwu_pkg::CFG_INV_SY,
                plwu_pkg::CFG_NEG_LOG_NORM, plwu_pkg::CFG_MISS_PENALTY};
        drain_results();
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_mark(input int slot, input int x, input int y, input logic [15:0] tag);
        plwu_pkg::t_in_item it;
        it = make_item(plwu_pkg::OP_LOAD, x, y);
        it.index = 6'(slot);
        it.landmark_tag = tag;
        send_item(it);
    endtask

    task automatic send_obs(input int x, input int y, input bit fin);
        plwu_pkg::t_in_item it;
        it = make_item(plwu_pkg::OP_OBS, x, y);
        it.final_obs = fin;
        send_item(it);
    endtask

    task automatic send_begin(input int x, input int y, input logic [15:0] hd);
        plwu_pkg::t_in_item it;
        it = make_item(plwu_pkg::OP_BEGIN, x, y);
        it.heading = hd;
        send_item(it);
    endtask

    task automatic run_particle(input bit wild);
        int k;
        k = $urandom_range(1, 6);
        send_begin(wild ? edge_coord() : near_coord(20),
                   wild ? edge_coord() : near_coord(20), 16'($urandom_range(0, 65535)));
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_obs(edge_coord(), edge_coord(), i == k - 1);
            else
                send_obs(near_coord(25), near_coord(25), i == k - 1);
        end
    endtask

    task automatic send_noise();
        plwu_pkg::t_in_item it;
        case ($urandom_range(0, 4))
            0: it = make_item(plwu_pkg::OP_LOAD, near_coord(30), near_coord(30));
            1: it = make_item(plwu_pkg::OP_LOAD, edge_coord(), edge_coord());
            2: it = make_item(plwu_pkg::OP_RSVD, int'($urandom()), int'($urandom()));
            3: it = make_item(plwu_pkg::OP_OBS, int'($urandom()), int'($urandom()));
            default: it = make_item(plwu_pkg::OP_BEGIN, int'($urandom()), int'($urandom()));
        endcase
        send_item(it);
    endtask

    task automatic random_phase(input int upto);
        while (items_sent < upto) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else run_particle($urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        int      x0;
        plwu_pkg::t_in_item it;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        items_sent = 0;
        tx_gaps = 1;
        rx_gap_odds = 20;
        rx_long_hold = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // observation before any begin, ignored opcode
        send_obs(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        it = make_item(plwu_pkg::OP_RSVD, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(it);
        send_obs(0, 0, 1'b1);

        // fill the whole table, two slots share a position for the tie case
        for (int j = 0; j < 64; j++)
            load_mark(j, near_coord(30), near_coord(30), 16'($urandom_range(0, 65535)));
        load_mark(0, 3 * METER, 0, 16'hFFFF);
        load_mark(1, 3 * METER, 0, 16'h0000);
        write_regs(64, 20 * METER, 65536, 65536, 32'h0002_0000, 100 * METER);

        send_begin(0, 0, 16'h0000);
        send_obs(3 * METER, 0, 1'b0);
        send_obs(0, 0, 1'b0);
        send_begin(0, 0, 16'h4000);
        send_obs(METER, 2 * METER, 1'b0);
        send_begin(METER, -METER, 16'h8000);
        send_obs(-2 * METER, METER, 1'b0);
        send_begin(0, 0, 16'hC000);
        send_obs(METER, METER, 1'b0);
        send_begin(0, 0, 16'hFFFF);
        send_obs(3 * METER, 0, 1'b1);
        send_obs(METER, 0, 1'b0);
        load_mark(5, METER, METER, 16'h0505);
        send_obs(METER, METER, 1'b1);
        send_begin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h3FFF);
        send_obs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_begin(32'h8000_0000, 32'h8000_0000, 16'h2000);
        send_obs(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        random_phase(400);
        write_regs(0, 32'h7FFF_FFFF, 32'hFF_FFFF, 0, 32'h8000_0000, 0);
        random_phase(550);
        write_regs(127, 32'h7FFF_FFFF, 0, 32'hFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_phase(750);

        write_regs(64, 30 * METER, 40000, 90000, 32'hFFF0_0000, 50 * METER);
        // long receiver hold while items keep coming
        rx_long_hold = 1;
        for (int i = 0; i < 12; i++) send_obs(near_coord(10), near_coord(10), i == 11);
        random_phase(950);
        drain_results();
        random_phase(1100);

        write_regs(10, 0, 65536, 65536, 32'h0001_0000, 7 * METER);
        random_phase(1250);
        x0 = $urandom_range(1, 64);
        write_regs(x0, $urandom_range(5 * METER, 40 * METER), $urandom_range(0, 24'hFF_FFFF),
                   $urandom_range(0, 24'hFF_FFFF), $urandom(), $urandom_range(0, 32'h7FFF_FFFF));
        random_phase(1500);

        write_regs(64, 25 * METER, 65536, 131072, 32'h0001_8000, 80 * METER);
        tx_gaps = 0;
        rx_gap_odds = 0;
        random_phase(1850);

        drain_results();
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
